// ===== src/gsq_pkg.sv =====
package gsq_pkg;

  localparam int unsigned SOUND_LINES_DEF = 8;
  localparam int unsigned LINE_W          = 8;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [15:0] SERVO_HOME_RST   = 16'd500;
  localparam logic [15:0] SERVO_TURNED_RST = 16'd2500;
  localparam logic [6:0]  PUMP_FULL_RST    = 7'd99;
  localparam logic [15:0] AUDIO_PULSE_RST  = 16'd1000;
  localparam logic [15:0] GRIP_HOLD_RST    = 16'd1000;
  localparam logic [15:0] REL_VENT_RST     = 16'd1500;
  localparam logic [15:0] REL_SETTLE_RST   = 16'd500;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_SUCK    = 3'd1,
    OP_RELEASE = 3'd2,
    OP_CANCEL  = 3'd3,
    OP_HOME    = 3'd4,
    OP_PLAY    = 3'd5
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SERVO_HOME   = 3'd0,
    CFG_SERVO_TURNED = 3'd1,
    CFG_PUMP_FULL    = 3'd2,
    CFG_AUDIO_PULSE  = 3'd3,
    CFG_GRIP_HOLD    = 3'd4,
    CFG_REL_VENT     = 3'd5,
    CFG_REL_SETTLE   = 3'd6
  } cfg_idx_t;

  // one-hot sequencer states
  typedef enum logic [6:0] {
    SEQ_NONE        = 7'b0000001,
    SEQ_SUCK_TURNED = 7'b0000010,
    SEQ_SUCK_PUMP   = 7'b0000100,
    SEQ_SUCK_HOLD   = 7'b0001000,
    SEQ_REL_TURNED  = 7'b0010000,
    SEQ_REL_VENT    = 7'b0100000,
    SEQ_REL_SETTLE  = 7'b1000000
  } seq_state_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_OK   = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] servo_home;
    logic [15:0] servo_turned;
    logic [6:0]  pump_full;
    logic [15:0] audio_pulse;
    logic [15:0] grip_hold;
    logic [15:0] rel_vent;
    logic [15:0] rel_settle;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] clip_number;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [15:0]       servo_pulse;
    logic [6:0]        pump_duty;
    logic              relay_on;
    logic [LINE_W-1:0] sound_lines;
    logic [1:0]        task_status;
    logic [3:0]        playing_clip;
  } result_t;

  // wrapping time difference against a 16-bit wait
  function automatic logic elapsed(input logic [31:0] now, input logic [31:0] start,
                                   input logic [15:0] wait_ms);
    logic [31:0] diff;
    diff = now - start;
    return diff >= {16'd0, wait_ms};
  endfunction

endpackage

// ===== src/gsq_cfg.sv =====
module gsq_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gsq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gsq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output gsq_pkg::cfg_t                    cfg
);

  gsq_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (gsq_pkg::cfg_idx_t'(cfg_index))
        gsq_pkg::CFG_SERVO_HOME:   cfg_nxt.servo_home   = cfg_wdata;
        gsq_pkg::CFG_SERVO_TURNED: cfg_nxt.servo_turned = cfg_wdata;
        gsq_pkg::CFG_PUMP_FULL:    cfg_nxt.pump_full    = cfg_wdata[6:0];
        gsq_pkg::CFG_AUDIO_PULSE:  cfg_nxt.audio_pulse  = cfg_wdata;
        gsq_pkg::CFG_GRIP_HOLD:    cfg_nxt.grip_hold    = cfg_wdata;
        gsq_pkg::CFG_REL_VENT:     cfg_nxt.rel_vent     = cfg_wdata;
        gsq_pkg::CFG_REL_SETTLE:   cfg_nxt.rel_settle   = cfg_wdata;
        default: ;  // index 7: no register
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.servo_home   <= gsq_pkg::SERVO_HOME_RST;
      cfg_r.servo_turned <= gsq_pkg::SERVO_TURNED_RST;
      cfg_r.pump_full    <= gsq_pkg::PUMP_FULL_RST;
      cfg_r.audio_pulse  <= gsq_pkg::AUDIO_PULSE_RST;
      cfg_r.grip_hold    <= gsq_pkg::GRIP_HOLD_RST;
      cfg_r.rel_vent     <= gsq_pkg::REL_VENT_RST;
      cfg_r.rel_settle   <= gsq_pkg::REL_SETTLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/gsq_core.sv =====
module gsq_core #(
  parameter int unsigned SOUND_LINES = gsq_pkg::SOUND_LINES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  gsq_pkg::item_t    item,
  input  gsq_pkg::cfg_t     cfg,
  output gsq_pkg::result_t  res_nxt
);

  gsq_pkg::seq_state_t seq_r, seq_nxt;
  gsq_pkg::status_t    status_r, status_nxt;
  logic [31:0]         seq_start_r, seq_start_nxt;
  logic [3:0]          clip_r, clip_nxt;
  logic [31:0]         clip_start_r, clip_start_nxt;
  logic [15:0]         servo_r, servo_nxt;
  logic [6:0]          pump_r, pump_nxt;
  logic                relay_r, relay_nxt;

  logic clip_ok;
  assign clip_ok = (item.clip_number != 16'd0) &&
                   (item.clip_number <= 16'(SOUND_LINES));

  always_comb begin
    seq_nxt        = seq_r;
    status_nxt     = status_r;
    seq_start_nxt  = seq_start_r;
    clip_nxt       = clip_r;
    clip_start_nxt = clip_start_r;
    servo_nxt      = servo_r;
    pump_nxt       = pump_r;
    relay_nxt      = relay_r;

    case (gsq_pkg::opcode_t'(item.opcode))
      gsq_pkg::OP_TICK: begin
        if (clip_r != 4'd0 &&
            gsq_pkg::elapsed(item.now_ms, clip_start_r, cfg.audio_pulse))
          clip_nxt = 4'd0;
        case (seq_r)
          gsq_pkg::SEQ_SUCK_TURNED: begin
            pump_nxt = cfg.pump_full;
            seq_nxt  = gsq_pkg::SEQ_SUCK_PUMP;
          end
          gsq_pkg::SEQ_SUCK_PUMP: begin
            seq_start_nxt = item.now_ms;
            seq_nxt       = gsq_pkg::SEQ_SUCK_HOLD;
          end
          gsq_pkg::SEQ_SUCK_HOLD: begin
            if (gsq_pkg::elapsed(item.now_ms, seq_start_r, cfg.grip_hold)) begin
              seq_nxt    = gsq_pkg::SEQ_NONE;
              status_nxt = gsq_pkg::ST_OK;
            end
          end
          gsq_pkg::SEQ_REL_TURNED: begin
            seq_start_nxt = item.now_ms;
            seq_nxt       = gsq_pkg::SEQ_REL_VENT;
          end
          gsq_pkg::SEQ_REL_VENT: begin
            if (gsq_pkg::elapsed(item.now_ms, seq_start_r, cfg.rel_vent)) begin
              pump_nxt      = 7'd0;
              relay_nxt     = 1'b0;
              seq_start_nxt = item.now_ms;
              seq_nxt       = gsq_pkg::SEQ_REL_SETTLE;
            end
          end
          gsq_pkg::SEQ_REL_SETTLE: begin
            if (gsq_pkg::elapsed(item.now_ms, seq_start_r, cfg.rel_settle)) begin
              servo_nxt  = cfg.servo_home;
              seq_nxt    = gsq_pkg::SEQ_NONE;
              status_nxt = gsq_pkg::ST_OK;
            end
          end
          default: seq_nxt = gsq_pkg::SEQ_NONE;
        endcase
      end
      gsq_pkg::OP_SUCK: begin
        servo_nxt     = cfg.servo_turned;
        relay_nxt     = 1'b1;
        seq_nxt       = gsq_pkg::SEQ_SUCK_TURNED;
        seq_start_nxt = item.now_ms;
        status_nxt    = gsq_pkg::ST_EXEC;
      end
      gsq_pkg::OP_RELEASE: begin
        servo_nxt     = cfg.servo_turned;
        seq_nxt       = gsq_pkg::SEQ_REL_TURNED;
        seq_start_nxt = item.now_ms;
        status_nxt    = gsq_pkg::ST_EXEC;
      end
      gsq_pkg::OP_CANCEL: begin
        clip_nxt   = 4'd0;
        seq_nxt    = gsq_pkg::SEQ_NONE;
        status_nxt = gsq_pkg::ST_IDLE;
      end
      gsq_pkg::OP_HOME: begin
        servo_nxt  = cfg.servo_home;
        status_nxt = gsq_pkg::ST_OK;
      end
      gsq_pkg::OP_PLAY: begin
        if (clip_ok) begin
          clip_nxt       = item.clip_number[3:0];
          clip_start_nxt = item.now_ms;
        end
      end
      default: ;  // opcodes 6 and 7 report state only
    endcase
  end

  // result shows the state after this beat
  always_comb begin
    res_nxt.servo_pulse  = servo_nxt;
    res_nxt.pump_duty    = pump_nxt;
    res_nxt.relay_on     = relay_nxt;
    res_nxt.task_status  = status_nxt;
    res_nxt.playing_clip = clip_nxt;
    for (int i = 0; i < int'(gsq_pkg::LINE_W); i++) begin
      res_nxt.sound_lines[i] = (clip_nxt != 4'(i + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r        <= gsq_pkg::SEQ_NONE;
      status_r     <= gsq_pkg::ST_IDLE;
      seq_start_r  <= 32'd0;
      clip_r       <= 4'd0;
      clip_start_r <= 32'd0;
      servo_r      <= gsq_pkg::SERVO_HOME_RST;
      pump_r       <= 7'd0;
      relay_r      <= 1'b0;
    end else if (fire) begin
      seq_r        <= seq_nxt;
      status_r     <= status_nxt;
      seq_start_r  <= seq_start_nxt;
      clip_r       <= clip_nxt;
      clip_start_r <= clip_start_nxt;
      servo_r      <= servo_nxt;
      pump_r       <= pump_nxt;
      relay_r      <= relay_nxt;
    end
  end

endmodule

// ===== src/suction_gripper_sequencer_unit.sv =====
// Channel  Dir  Handshake              Payload
// in_      in   in_valid / in_ready    in_opcode, in_clip_number, in_now_ms
// out_     out  out_valid / out_ready  servo, pump, relay, sound lines, status, clip
// cfg_     in   cfg_we (no wait)       cfg_index, cfg_wdata
//
// One beat in, one beat out; a new beat every cycle unless the output stalls.
// A beat passes the input register, then the state update into the result register.
// The result register decouples the sides: the input stage can still fill while a
// result waits, and both hold under stall with no beat dropped.
// Synchronous active-low reset clears the sequencer, clip timer and actuator state.
module suction_gripper_sequencer_unit #(
  parameter int unsigned SOUND_LINES = gsq_pkg::SOUND_LINES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_opcode,
  input  logic [15:0]                         in_clip_number,
  input  logic [31:0]                         in_now_ms,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [15:0]                         out_servo_pulse,
  output logic [6:0]                          out_pump_duty,
  output logic                                out_relay_on,
  output logic [gsq_pkg::LINE_W-1:0]          out_sound_lines,
  output logic [1:0]                          out_task_status,
  output logic [3:0]                          out_playing_clip,

  input  logic                                cfg_we,
  input  logic [gsq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gsq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  gsq_pkg::cfg_t    cfg;
  gsq_pkg::item_t   item_r;
  gsq_pkg::result_t res_r, res_nxt;
  logic             in_vld_r;
  logic             out_vld_r;
  logic             adv;        // input stage moves into the result register
  logic             in_fire;

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;
  assign in_fire  = in_valid && in_ready;

  gsq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // state commits only when the beat leaves the input stage
  gsq_core #(
    .SOUND_LINES (SOUND_LINES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (adv),
    .item    (item_r),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.opcode      <= in_opcode;
      item_r.clip_number <= in_clip_number;
      item_r.now_ms      <= in_now_ms;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_servo_pulse  = res_r.servo_pulse;
  assign out_pump_duty    = res_r.pump_duty;
  assign out_relay_on     = res_r.relay_on;
  assign out_sound_lines  = res_r.sound_lines;
  assign out_task_status  = res_r.task_status;
  assign out_playing_clip = res_r.playing_clip;

  // a blocked input stage keeps its beat
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> in_vld_r)
    else $error("input stage lost a beat");

  // reported clip never exceeds the number of lines
  a_clip_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_playing_clip <= 4'(SOUND_LINES)))
    else $error("playing clip out of range");

  // at most one sound line low, none when no clip plays
  a_one_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(~out_sound_lines) <= 1))
    else $error("more than one sound line active");

  a_no_clip_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_playing_clip == 4'd0) |-> (&out_sound_lines))
    else $error("sound line low with no clip");

endmodule

// ===== tb/testbench.sv =====
module testbench;

  // generous cycle budget for a clean run
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_opcode;
  logic [15:0] in_clip_number;
  logic [31:0] in_now_ms;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_servo_pulse;
  logic [6:0]  out_pump_duty;
  logic        out_relay_on;
  logic [gsq_pkg::LINE_W-1:0] out_sound_lines;
  logic [1:0]  out_task_status;
  logic [3:0]  out_playing_clip;
  logic                           cfg_we;
  logic [gsq_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gsq_pkg::CFG_DATA_W-1:0] cfg_wdata;

  suction_gripper_sequencer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_clip_number   (in_clip_number),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_servo_pulse  (out_servo_pulse),
    .out_pump_duty    (out_pump_duty),
    .out_relay_on     (out_relay_on),
    .out_sound_lines  (out_sound_lines),
    .out_task_status  (out_task_status),
    .out_playing_clip (out_playing_clip),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Clock: 2 time units, high then low
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the sequencer: registers, timers, actuators
  // ---------------------------------------------------------------------------
  gsq_pkg::cfg_t        regs_model;
  gsq_pkg::seq_state_t  seq_phase;
  logic [31:0]          seq_t0;
  logic [31:0]          clip_t0;
  logic [3:0]           clip_now;
  logic [15:0]          servo_now;
  logic [6:0]           pump_now;
  logic                 relay_now;
  gsq_pkg::status_t     status_now;

  gsq_pkg::result_t     pending_readouts[$];   // one readout per accepted command beat

  int unsigned cycle_count;
  int unsigned beats_sent;
  int unsigned readouts_checked;
  int unsigned reg_writes;
  int unsigned mismatches;
  bit          calm;                  // no idling on either side while set
  logic [31:0] wall_ms;               // running millisecond clock for stimulus

  function automatic void reset_model();
    regs_model.servo_home   = gsq_pkg::SERVO_HOME_RST;
    regs_model.servo_turned = gsq_pkg::SERVO_TURNED_RST;
    regs_model.pump_full    = gsq_pkg::PUMP_FULL_RST;
    regs_model.audio_pulse  = gsq_pkg::AUDIO_PULSE_RST;
    regs_model.grip_hold    = gsq_pkg::GRIP_HOLD_RST;
    regs_model.rel_vent     = gsq_pkg::REL_VENT_RST;
    regs_model.rel_settle   = gsq_pkg::REL_SETTLE_RST;
    seq_phase  = gsq_pkg::SEQ_NONE;
    seq_t0     = '0;
    clip_t0    = '0;
    clip_now   = '0;
    servo_now  = gsq_pkg::SERVO_HOME_RST;
    pump_now   = '0;
    relay_now  = 1'b0;
    status_now = gsq_pkg::ST_IDLE;
  endfunction

  // wrapping mod 2^32 difference against a 16-bit wait
  function automatic bit waited(input logic [31:0] now, input logic [31:0] t0,
                                input logic [15:0] span);
    logic [31:0] gap;
    gap = now - t0;
    return gap >= {16'd0, span};
  endfunction

  // Apply one command beat to the shadow and queue the readout it yields.
  task automatic predict_actuators(input logic [2:0] op, input logic [15:0] clip,
                                   input logic [31:0] now);
    gsq_pkg::result_t want;
    case (op)
      gsq_pkg::OP_TICK: begin
        // clip timer first, then at most one sequence step
        if (clip_now != 0 && waited(now, clip_t0, regs_model.audio_pulse))
          clip_now = '0;
        case (seq_phase)
          gsq_pkg::SEQ_SUCK_TURNED: begin
            pump_now  = regs_model.pump_full;
            seq_phase = gsq_pkg::SEQ_SUCK_PUMP;
          end
          gsq_pkg::SEQ_SUCK_PUMP: begin
            seq_t0    = now;
            seq_phase = gsq_pkg::SEQ_SUCK_HOLD;
          end
          gsq_pkg::SEQ_SUCK_HOLD: begin
            if (waited(now, seq_t0, regs_model.grip_hold)) begin
              seq_phase  = gsq_pkg::SEQ_NONE;
              status_now = gsq_pkg::ST_OK;
            end
          end
          gsq_pkg::SEQ_REL_TURNED: begin
            seq_t0    = now;
            seq_phase = gsq_pkg::SEQ_REL_VENT;
          end
          gsq_pkg::SEQ_REL_VENT: begin
            if (waited(now, seq_t0, regs_model.rel_vent)) begin
              pump_now  = '0;
              relay_now = 1'b0;
              seq_t0    = now;
              seq_phase = gsq_pkg::SEQ_REL_SETTLE;
            end
          end
          gsq_pkg::SEQ_REL_SETTLE: begin
            if (waited(now, seq_t0, regs_model.rel_settle)) begin
              servo_now  = regs_model.servo_home;
              seq_phase  = gsq_pkg::SEQ_NONE;
              status_now = gsq_pkg::ST_OK;
            end
          end
          default: seq_phase = gsq_pkg::SEQ_NONE;
        endcase
      end
      gsq_pkg::OP_SUCK: begin
        servo_now  = regs_model.servo_turned;
        relay_now  = 1'b1;
        seq_phase  = gsq_pkg::SEQ_SUCK_TURNED;
        seq_t0     = now;
        status_now = gsq_pkg::ST_EXEC;
      end
      gsq_pkg::OP_RELEASE: begin
        servo_now  = regs_model.servo_turned;
        seq_phase  = gsq_pkg::SEQ_REL_TURNED;
        seq_t0     = now;
        status_now = gsq_pkg::ST_EXEC;
      end
      gsq_pkg::OP_CANCEL: begin
        // actuators keep their values
        clip_now   = '0;
        seq_phase  = gsq_pkg::SEQ_NONE;
        status_now = gsq_pkg::ST_IDLE;
      end
      gsq_pkg::OP_HOME: begin
        // a running sequence keeps running
        servo_now  = regs_model.servo_home;
        status_now = gsq_pkg::ST_OK;
      end
      gsq_pkg::OP_PLAY: begin
        // out-of-range clip numbers are dropped; same clip restarts with no gap
        if (clip >= 1 && clip <= gsq_pkg::SOUND_LINES_DEF) begin
          clip_now = clip[3:0];
          clip_t0  = now;
        end
      end
      default: ;  // opcodes 6 and 7 only report state
    endcase
    want.servo_pulse = servo_now;
    want.pump_duty   = pump_now;
    want.relay_on    = relay_now;
    want.sound_lines = '1;
    if (clip_now != 0)
      want.sound_lines[clip_now - 1] = 1'b0;
    want.task_status  = status_now;
    want.playing_clip = clip_now;
    pending_readouts.push_back(want);
  endtask

  function automatic string show(input gsq_pkg::result_t r);
    return $sformatf("servo=%0d pump=%0d relay=%0d lines=%02h status=%0d clip=%0d",
                     r.servo_pulse, r.pump_duty, r.relay_on, r.sound_lines,
                     r.task_status, r.playing_clip);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    gsq_pkg::result_t got;
    gsq_pkg::result_t want;
    if (rst_n) begin
      // input beat accepted -> predict its readout
      if (in_valid && in_ready)
        predict_actuators(in_opcode, in_clip_number, in_now_ms);
      // output beat accepted -> compare against oldest prediction
      if (out_valid && out_ready) begin
        got.servo_pulse  = out_servo_pulse;
        got.pump_duty    = out_pump_duty;
        got.relay_on     = out_relay_on;
        got.sound_lines  = out_sound_lines;
        got.task_status  = out_task_status;
        got.playing_clip = out_playing_clip;
        if (pending_readouts.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("unexpected readout beat: %s", show(got));
        end else begin
          want = pending_readouts.pop_front();
          readouts_checked++;
          if (got.servo_pulse !== want.servo_pulse || got.pump_duty !== want.pump_duty ||
              got.relay_on !== want.relay_on || got.sound_lines !== want.sound_lines ||
              got.task_status !== want.task_status ||
              got.playing_clip !== want.playing_clip) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES) begin
              $display("mismatch on readout %0d", readouts_checked);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readouts outstanding",
               cycle_count, pending_readouts.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver backpressure: ~31% stall, none while calm
  // ---------------------------------------------------------------------------
  always @(negedge clk)
    out_ready = calm || ($urandom_range(0, 99) >= 31);

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 31);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------
  // One command beat; valid holds with a steady payload until accepted.
  task automatic send_cmd(input logic [2:0] op, input logic [15:0] clip,
                          input logic [31:0] now);
    @(negedge clk);
    while (take_break()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_opcode      = op;
    in_clip_number = clip;
    in_now_ms      = now;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Stop sending and let every predicted readout come back.
  task automatic wait_all_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_readouts.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);  // covers the input and result registers
  endtask

  task automatic write_reg(input gsq_pkg::cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    reg_writes++;
    case (idx)
      gsq_pkg::CFG_SERVO_HOME:   regs_model.servo_home   = val;
      gsq_pkg::CFG_SERVO_TURNED: regs_model.servo_turned = val;
      gsq_pkg::CFG_PUMP_FULL:    regs_model.pump_full    = val[6:0];
      gsq_pkg::CFG_AUDIO_PULSE:  regs_model.audio_pulse  = val;
      gsq_pkg::CFG_GRIP_HOLD:    regs_model.grip_hold    = val;
      gsq_pkg::CFG_REL_VENT:     regs_model.rel_vent     = val;
      gsq_pkg::CFG_REL_SETTLE:   regs_model.rel_settle   = val;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [15:0] home, input logic [15:0] turned,
                                input logic [15:0] pump, input logic [15:0] audio,
                                input logic [15:0] hold, input logic [15:0] vent,
                                input logic [15:0] settle);
    write_reg(gsq_pkg::CFG_SERVO_HOME, home);
    write_reg(gsq_pkg::CFG_SERVO_TURNED, turned);
    write_reg(gsq_pkg::CFG_PUMP_FULL, pump);
    write_reg(gsq_pkg::CFG_AUDIO_PULSE, audio);
    write_reg(gsq_pkg::CFG_GRIP_HOLD, hold);
    write_reg(gsq_pkg::CFG_REL_VENT, vent);
    write_reg(gsq_pkg::CFG_REL_SETTLE, settle);
  endtask

  // mostly small steps, sometimes big jumps or a fresh random time
  function automatic logic [31:0] next_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3)
      wall_ms = $urandom();
    else if (r < 8)
      wall_ms = wall_ms + $urandom_range(0, 70000);
    else
      wall_ms = wall_ms + $urandom_range(0, 4);
    return wall_ms;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset values visible on a tick; unknown opcodes only report state.
  task automatic test_reset_state();
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'd0);
    send_cmd(3'd6, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(3'd7, 16'h5A5A, 32'h8000_0000);
    wait_all_results();
  endtask

  // Full suck and release sequences at reset timing, including a not-yet tick.
  task automatic test_suck_release();
    send_cmd(gsq_pkg::OP_SUCK, 16'd0, 32'd100);
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'd101);   // pump starts
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'd102);   // hold timer starts
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'd1101);  // one ms short
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'd1102);  // grip done
    send_cmd(gsq_pkg::OP_RELEASE, 16'd0, 32'd1200);
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'd1201);  // vent timer starts
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'd2701);  // pump and relay off
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'd3201);  // servo homes
    wait_all_results();
  endtask

  // Clip range edges, replacement, expiry across the 2^32 wrap, retrigger, cancel.
  task automatic test_clips();
    send_cmd(gsq_pkg::OP_PLAY, 16'd0, 32'd10);
    send_cmd(gsq_pkg::OP_PLAY, 16'd9, 32'd11);
    send_cmd(gsq_pkg::OP_PLAY, 16'd8, 32'hFFFF_FE00);
    send_cmd(gsq_pkg::OP_PLAY, 16'd1, 32'hFFFF_FF00);  // replaces clip 8
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'h0000_02E7);  // 999 ms after wrap
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'h0000_02E8);  // expires
    send_cmd(gsq_pkg::OP_PLAY, 16'd1, 32'h0000_0300);
    send_cmd(gsq_pkg::OP_PLAY, 16'd1, 32'h0000_0301);  // same clip again, no gap
    send_cmd(gsq_pkg::OP_CANCEL, 16'd0, 32'h0000_0302);
    wait_all_results();
  endtask

  // All registers at zero (waits end on next tick), then all at maximum.
  task automatic test_register_extremes();
    write_all_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_cmd(gsq_pkg::OP_SUCK, 16'd0, 32'd5000);
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'd5000);
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'd5000);
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'd5000);
    send_cmd(gsq_pkg::OP_RELEASE, 16'd0, 32'd5000);
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'd5000);
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'd5000);
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'd5000);
    wait_all_results();
    // pump write carries upper bits that the 7-bit register drops
    write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(gsq_pkg::OP_SUCK, 16'd0, 32'd6000);
    send_cmd(gsq_pkg::OP_TICK, 16'd0, 32'd6001);  // pump above 99 passes through
    send_cmd(gsq_pkg::OP_HOME, 16'd0, 32'd6002);
    wait_all_results();
  endtask

  // One random phase: fresh register set, then mostly command-plus-tick runs.
  task automatic run_random_phase(input int unsigned n_items, input int unsigned wait_span,
                                  input bit pause_mid);
    int unsigned stop_at;
    int unsigned pause_at;
    int unsigned pick;
    int unsigned run_len;
    logic [15:0] pump_w;
    pump_w = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 99)) : 16'($urandom());
    write_all_regs(16'($urandom()), 16'($urandom()), pump_w,
                   16'($urandom_range(0, wait_span)), 16'($urandom_range(0, wait_span)),
                   16'($urandom_range(0, wait_span)), 16'($urandom_range(0, wait_span)));
    stop_at  = beats_sent + n_items;
    pause_at = beats_sent + n_items / 2;
    while (beats_sent < stop_at) begin
      if (pause_mid && beats_sent >= pause_at) begin
        // sender holds off until the block has drained
        wait_all_results();
        pause_mid = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // well-formed: suck or release, then a run of ticks with some clips mixed in
        send_cmd((pick < 35) ? 3'(gsq_pkg::OP_SUCK) : 3'(gsq_pkg::OP_RELEASE),
                 16'($urandom()), next_time());
        run_len = $urandom_range(3, 25);
        repeat (run_len) begin
          if ($urandom_range(0, 9) == 0)
            send_cmd(gsq_pkg::OP_PLAY, 16'($urandom_range(1, gsq_pkg::SOUND_LINES_DEF)),
                     next_time());
          else
            send_cmd(gsq_pkg::OP_TICK, 16'($urandom()), next_time());
        end
      end else if (pick < 80) begin
        send_cmd(gsq_pkg::OP_PLAY, ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
                 16'($urandom_range(1, gsq_pkg::SOUND_LINES_DEF)), next_time());
      end else if (pick < 86) begin
        send_cmd(gsq_pkg::OP_CANCEL, 16'($urandom()), next_time());
      end else if (pick < 92) begin
        send_cmd(gsq_pkg::OP_HOME, 16'($urandom()), next_time());
      end else begin
        // noise: any opcode, any payload
        send_cmd(3'($urandom_range(0, 7)), 16'($urandom()), $urandom());
      end
    end
    wait_all_results();
  endtask

  task automatic test_random();
    wall_ms = 32'hFFFF_FF80;  // first phase crosses the wrap
    run_random_phase(100, 20, 1'b0);
    run_random_phase(100, 40, 1'b1);
    calm = 1'b1;              // back-to-back beats, no stalls
    run_random_phase(100, 20, 1'b0);
    calm = 1'b0;
    run_random_phase(100, 65535, 1'b0);
    run_random_phase(100, 8, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = '0;
    in_clip_number = '0;
    in_now_ms      = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    calm           = 1'b0;
    wall_ms        = '0;
    reset_model();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_suck_release();
    test_clips();
    test_register_extremes();
    test_random();

    wait_all_results();
    $display("covered %0d command beats over 8 register settings (%0d writes),",
             beats_sent, reg_writes);
    $display("%0d readouts checked, %0d mismatches", readouts_checked, mismatches);
    if (mismatches == 0 && pending_readouts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/gsq_pkg.sv
src/gsq_cfg.sv
src/gsq_core.sv
src/suction_gripper_sequencer_unit.sv
tb/testbench.sv
